// File: src/size_class_free_list_allocator_unit_macros.svh
// assertion macros for the size class allocator
// each checks on the rising edge of clk and is off while rst_n is low
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SCFL_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("allocator check failed");
// next-cycle implication
`define SCFL_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator check failed");
`else
`define SCFL_ASSERT_IMP(name, pre, post)
`define SCFL_ASSERT_NXT(name, pre, post)
`endif

`endif

// File: src/scfl_pkg.sv
`default_nettype none

package scfl_pkg;

    // default configuration
    localparam int SCFL_SIZE_CLASSES = 16;
    localparam int SCFL_ARENA_BYTES  = 4096;

    // fixed geometry
    localparam int CLASS_STEP = 8;
    localparam int STEP_SHIFT = $clog2(CLASS_STEP);
    localparam int ADDR_W     = 16;
    localparam int LINK_AW    = ADDR_W - STEP_SHIFT;
    localparam int LINK_W     = ADDR_W + 1;
    localparam int CB_W       = 6 + STEP_SHIFT;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_FREED     = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] block_address;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [7:0]        class_bytes;
    } rsp_item_t;

    // decode flags handed from the decoder to the control
    typedef struct packed {
        logic is_free;
        logic reject;
    } dec_flags_t;

    // width of a class index
    function automatic int cls_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// File: src/scfl_decode.sv
`default_nettype none

module scfl_decode #(
    parameter int SIZE_CLASSES = scfl_pkg::SCFL_SIZE_CLASSES,
    parameter int ARENA_BYTES  = scfl_pkg::SCFL_ARENA_BYTES,
    localparam int CW = scfl_pkg::cls_width(SIZE_CLASSES)
) (
    input  wire scfl_pkg::req_item_t  req,
    output logic [CW-1:0]             cls,
    output scfl_pkg::dec_flags_t      flags,
    output logic [scfl_pkg::ADDR_W-1:0] base
);
    import scfl_pkg::*;

    localparam int QW = ADDR_W + 1 - STEP_SHIFT;
    localparam logic [ADDR_W-1:0] ARENA_LO = ADDR_W'(ARENA_BYTES);

    logic [ADDR_W:0] round_sum;
    logic [QW-1:0]   blocks;
    logic [QW-1:0]   cls_wide;
    logic            too_large;
    logic [31:0]     addr_ext;
    logic [CW-1:0]   cls_free;
    logic            beyond;

    // size to class: round up, zero counts as the smallest class
    always_comb
    begin
        round_sum = {1'b0, req.request_bytes} + (ADDR_W + 1)'(CLASS_STEP - 1);
        blocks    = round_sum[ADDR_W:STEP_SHIFT];
        cls_wide  = (blocks == '0) ? '0 : blocks - 1'b1;
        too_large = cls_wide >= QW'(SIZE_CLASSES);
    end

    // address to class: compare against every arena boundary
    always_comb
    begin
        addr_ext = 32'(req.block_address);
        cls_free = '0;
        for (int k = 0; k < SIZE_CLASSES; k++)
        begin
            if ((addr_ext >= 32'(k * ARENA_BYTES)) &&
                (addr_ext < 32'((k + 1) * ARENA_BYTES)))
            begin
                cls_free = cls_free | CW'(k);
            end
        end
        beyond = addr_ext >= 32'(SIZE_CLASSES * ARENA_BYTES);
    end

    // select by command, arena base wraps to the address width
    always_comb
    begin
        flags.is_free = (req.command == CMD_FREE);
        cls           = flags.is_free ? cls_free : cls_wide[CW-1:0];
        flags.reject  = flags.is_free ? beyond : too_large;
        base          = ADDR_W'(cls * ARENA_LO);
    end

endmodule

`default_nettype wire

// File: src/scfl_class_store.sv
`default_nettype none

module scfl_class_store #(
    parameter int SIZE_CLASSES = scfl_pkg::SCFL_SIZE_CLASSES,
    parameter int ARENA_BYTES  = scfl_pkg::SCFL_ARENA_BYTES,
    localparam int CW      = scfl_pkg::cls_width(SIZE_CLASSES),
    localparam int FRESH_W = $clog2(ARENA_BYTES + 1),
    localparam int ENTRY_W = scfl_pkg::ADDR_W + 1 + FRESH_W
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                rd_en,
    input  wire  [CW-1:0]      rd_addr,
    input  wire                wr_en,
    input  wire  [CW-1:0]      wr_addr,
    input  wire  [ENTRY_W-1:0] wr_data,
    output logic [ENTRY_W-1:0] rd_data
);
    import scfl_pkg::*;

    logic [ENTRY_W-1:0]      mem [SIZE_CLASSES];
    logic [SIZE_CLASSES-1:0] valid_reg;
    logic [ENTRY_W-1:0]      rdata_reg;
    logic                    rvalid_reg;
    logic                    fwd_hit_reg;
    logic [ENTRY_W-1:0]      fwd_data_reg;

    // class state array, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // per-class valid bits give the reset value until first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rvalid_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg  <= valid_reg[rd_addr];
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // forward a write that lands with the read
    assign rd_data = fwd_hit_reg ? fwd_data_reg : (rvalid_reg ? rdata_reg : '0);

endmodule

`default_nettype wire

// File: src/scfl_link_store.sv
`default_nettype none

module scfl_link_store (
    input  wire                           clk,
    input  wire                           rd_en,
    input  wire  [scfl_pkg::LINK_AW-1:0]  rd_addr,
    input  wire                           wr_en,
    input  wire  [scfl_pkg::LINK_AW-1:0]  wr_addr,
    input  wire  [scfl_pkg::LINK_W-1:0]   wr_data,
    output logic [scfl_pkg::LINK_W-1:0]   rd_data
);
    import scfl_pkg::*;

    localparam int LINK_DEPTH = 1 << LINK_AW;

    logic [LINK_W-1:0] mem [LINK_DEPTH];
    logic [LINK_W-1:0] rdata_reg;

    // link words indexed by block address, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

`default_nettype wire

// File: src/size_class_free_list_allocator_unit.sv
// result: registered from S_CLS once the result slot is free, or from S_LINK when
//   an allocate pops a freed block (link memory read before the class head update)
// throughput: 1 item per cycle when results drain, a stack pop holds the next item
// reset: control and class state clear at once (valid bit per class), link memory
//   holds no reset value and needs no clearing pass
`default_nettype none
`include "size_class_free_list_allocator_unit_macros.svh"

module size_class_free_list_allocator_unit #(
    parameter int SIZE_CLASSES = scfl_pkg::SCFL_SIZE_CLASSES,
    parameter int ARENA_BYTES  = scfl_pkg::SCFL_ARENA_BYTES
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire scfl_pkg::req_item_t req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output scfl_pkg::rsp_item_t rsp
);
    import scfl_pkg::*;

    localparam int CW      = cls_width(SIZE_CLASSES);
    localparam int FRESH_W = $clog2(ARENA_BYTES + 1);
    localparam int ENTRY_W = ADDR_W + 1 + FRESH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLS  = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;
    logic              free_reg;
    logic              reject_reg;
    logic [CW-1:0]     cls_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [CW-1:0]     dec_cls;
    dec_flags_t        dec_flags;
    logic [ADDR_W-1:0] dec_base;

    logic               accept;
    logic               finish;
    logic               pop;
    logic               slot_free;
    logic [ENTRY_W-1:0] entry;
    logic [ADDR_W-1:0]  e_top;
    logic               e_ne;
    logic [FRESH_W-1:0] e_off;
    logic [5:0]         cls_p1;
    logic [CB_W-1:0]    cb;
    logic [FRESH_W:0]   off_sum;
    logic               fits;

    logic               cls_wr_en;
    logic [ENTRY_W-1:0] cls_wr_data;
    logic               link_rd_en;
    logic               link_wr_en;
    logic [LINK_W-1:0]  link_rd_data;

    scfl_decode #(
        .SIZE_CLASSES (SIZE_CLASSES),
        .ARENA_BYTES  (ARENA_BYTES)
    ) u_decode (
        .req   (req),
        .cls   (dec_cls),
        .flags (dec_flags),
        .base  (dec_base)
    );

    scfl_class_store #(
        .SIZE_CLASSES (SIZE_CLASSES),
        .ARENA_BYTES  (ARENA_BYTES)
    ) u_class_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (dec_cls),
        .wr_en   (cls_wr_en),
        .wr_addr (cls_reg),
        .wr_data (cls_wr_data),
        .rd_data (entry)
    );

    scfl_link_store u_link_store (
        .clk     (clk),
        .rd_en   (link_rd_en),
        .rd_addr (e_top[ADDR_W-1:STEP_SHIFT]),
        .wr_en   (link_wr_en),
        .wr_addr (addr_reg[ADDR_W-1:STEP_SHIFT]),
        .wr_data ({e_ne, e_top}),
        .rd_data (link_rd_data)
    );

    // class entry fields and fresh block arithmetic
    always_comb
    begin
        e_top   = entry[ENTRY_W-1 -: ADDR_W];
        e_ne    = entry[FRESH_W];
        e_off   = entry[FRESH_W-1:0];
        cls_p1  = 6'(cls_reg) + 6'd1;
        cb      = {cls_p1, {STEP_SHIFT{1'b0}}};
        off_sum = {1'b0, e_off} + (FRESH_W + 1)'(cb);
        fits    = off_sum <= (FRESH_W + 1)'(ARENA_BYTES);
    end

    // handshake and sequencing
    always_comb
    begin
        slot_free = !rsp_valid_reg || rsp_ready;
        pop       = (state_reg == S_CLS) && !free_reg && !reject_reg && e_ne;
        finish    = (((state_reg == S_CLS) && !pop) || (state_reg == S_LINK)) && slot_free;
        req_ready = (state_reg == S_IDLE) || finish;
        accept    = req_valid && req_ready;
    end

    // state update, memory writes and result
    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cls_wr_en      = 1'b0;
        cls_wr_data    = entry;
        link_rd_en     = 1'b0;
        link_wr_en     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CLS;
                end
            end
            S_CLS:
            begin
                if (pop)
                begin
                    link_rd_en = 1'b1;
                    state_next = S_LINK;
                end
                else if (finish)
                begin
                    state_next     = accept ? S_CLS : S_IDLE;
                    rsp_valid_next = 1'b1;
                    if (reject_reg)
                    begin
                        rsp_next.status          = free_reg ? ST_FREED : ST_TOO_LARGE;
                        rsp_next.granted_address = '0;
                        rsp_next.class_bytes     = '0;
                    end
                    else if (free_reg)
                    begin
                        link_wr_en               = 1'b1;
                        cls_wr_en                = 1'b1;
                        cls_wr_data              = {addr_reg, 1'b1, e_off};
                        rsp_next.status          = ST_FREED;
                        rsp_next.granted_address = '0;
                        rsp_next.class_bytes     = cb[7:0];
                    end
                    else if (fits)
                    begin
                        cls_wr_en                = 1'b1;
                        cls_wr_data              = {e_top, e_ne, off_sum[FRESH_W-1:0]};
                        rsp_next.status          = ST_ALLOCATED;
                        rsp_next.granted_address = base_reg + ADDR_W'(e_off);
                        rsp_next.class_bytes     = cb[7:0];
                    end
                    else
                    begin
                        rsp_next.status          = ST_EXHAUSTED;
                        rsp_next.granted_address = '0;
                        rsp_next.class_bytes     = cb[7:0];
                    end
                end
            end
            S_LINK:
            begin
                if (finish)
                begin
                    state_next     = accept ? S_CLS : S_IDLE;
                    rsp_valid_next = 1'b1;
                    cls_wr_en      = 1'b1;
                    cls_wr_data    = {(link_rd_data[ADDR_W] ? link_rd_data[ADDR_W-1:0] : '0),
                                      link_rd_data[ADDR_W], e_off};
                    rsp_next.status          = ST_ALLOCATED;
                    rsp_next.granted_address = e_top;
                    rsp_next.class_bytes     = cb[7:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            free_reg   <= dec_flags.is_free;
            reject_reg <= dec_flags.reject;
            cls_reg    <= dec_cls;
            base_reg   <= dec_base;
            addr_reg   <= req.block_address;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `SCFL_ASSERT_NXT(a_accept_reads_class, accept, state_reg == S_CLS)
    `SCFL_ASSERT_NXT(a_pop_waits_link, link_rd_en, state_reg == S_LINK)
    `SCFL_ASSERT_NXT(a_finish_shows_result, finish, rsp_valid_reg)
    `SCFL_ASSERT_IMP(a_link_one_access, link_wr_en, !link_rd_en && !pop)

endmodule

`default_nettype wire

// File: bench/tb_size_class_free_list_allocator_unit.sv
`default_nettype none

module tb_size_class_free_list_allocator_unit;

    import scfl_pkg::*;

    localparam int NUM_CLASSES  = SCFL_SIZE_CLASSES;
    localparam int ARENA_SIZE   = SCFL_ARENA_BYTES;
    localparam int LINK_DEPTH   = 1 << LINK_AW;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 20;

    // one row of the directed script
    typedef struct packed {
        req_item_t item;
        logic      typed;
        rsp_item_t want;
    } script_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    // shadow of the allocator state
    logic [ADDR_W-1:0] class_head     [NUM_CLASSES];
    logic              class_has_free [NUM_CLASSES];
    int unsigned       class_bumped   [NUM_CLASSES];
    logic [LINK_W-1:0] link_words     [LINK_DEPTH];

    rsp_item_t         predicted_outcomes[$];
    logic [ADDR_W-1:0] live_blocks[$];
    script_row_t       script_rows[$];
    rsp_item_t         oldest_outcome;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned items_checked = 0;
    int unsigned outcome_count [4];
    int          req_gap_pct = 0;
    int          rsp_stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;

    size_class_free_list_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     predicted_outcomes.size());
            $display("tb_size_class_free_list_allocator_unit NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, field,
                     got, want);
        mismatches++;
    endtask

    function automatic int unsigned link_slot(input logic [ADDR_W-1:0] addr);
        return (32'(addr) / CLASS_STEP) % LINK_DEPTH;
    endfunction

    // expected outcome of one item, updating the shadow state
    function automatic rsp_item_t predict_allocation(input req_item_t item);
        rsp_item_t         r;
        int unsigned       rounded;
        int unsigned       cls;
        int unsigned       cb;
        logic [ADDR_W-1:0] got;
        logic [LINK_W-1:0] lnk;
        r = '0;
        if (item.command == CMD_ALLOC)
        begin
            rounded = 32'(item.request_bytes);
            rounded = (rounded + CLASS_STEP - 1) / CLASS_STEP * CLASS_STEP;
            if (rounded == 0)
                rounded = CLASS_STEP;
            cls = rounded / CLASS_STEP - 1;
            if (cls >= NUM_CLASSES)
            begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            cb = rounded;
            r.class_bytes = 8'(cb);
            if (class_has_free[cls])
            begin
                // pop the class stack
                got = class_head[cls];
                lnk = link_words[link_slot(got)];
                if (lnk[ADDR_W])
                    class_head[cls] = lnk[ADDR_W-1:0];
                else
                begin
                    class_has_free[cls] = 1'b0;
                    class_head[cls] = '0;
                end
                r.status = ST_ALLOCATED;
                r.granted_address = got;
            end
            else if (class_bumped[cls] < ARENA_SIZE / cb)
            begin
                // next untouched block of the arena
                r.status = ST_ALLOCATED;
                r.granted_address = 16'(cls * ARENA_SIZE + class_bumped[cls] * cb);
                class_bumped[cls]++;
            end
            else
                r.status = ST_EXHAUSTED;
        end
        else
        begin
            cls = 32'(item.block_address) / ARENA_SIZE;
            r.status = ST_FREED;
            if (cls < NUM_CLASSES)
            begin
                // push, no check on the address
                link_words[link_slot(item.block_address)] = {class_has_free[cls],
                                                             class_head[cls]};
                class_head[cls] = item.block_address;
                class_has_free[cls] = 1'b1;
                r.class_bytes = 8'((cls + 1) * CLASS_STEP);
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic cmd, input logic [15:0] bytes,
                           input logic [15:0] addr, input logic typed,
                           input logic [1:0] st, input logic [15:0] granted,
                           input logic [7:0] cb);
        script_row_t row;
        row.item.command = cmd;
        row.item.request_bytes = bytes;
        row.item.block_address = addr;
        row.typed = typed;
        row.want.status = st;
        row.want.granted_address = granted;
        row.want.class_bytes = cb;
        script_rows.push_back(row);
    endtask

    // offer one item and record its outcome once accepted
    // valid stays high after the accept until the next call drives it
    task automatic send_item(input req_item_t item, input logic typed,
                             input rsp_item_t want);
        rsp_item_t got;
        while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
        got = predict_allocation(item);
        predicted_outcomes.push_back(typed ? want : got);
        if (item.command == CMD_ALLOC && got.status == ST_ALLOCATED)
            live_blocks.push_back(got.granted_address);
        items_sent++;
    endtask

    // mostly allocate and give back live blocks, with some stray frees
    function automatic req_item_t make_random_item();
        req_item_t   it;
        int unsigned pick;
        int unsigned slot;
        it.command = CMD_ALLOC;
        it.request_bytes = 16'($urandom);
        it.block_address = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 62)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                it.request_bytes = 16'($urandom_range(128, 97));
            else if (pick < 80)
                it.request_bytes = 16'($urandom_range(8, 0));
            else if (pick < 90)
                it.request_bytes = 16'($urandom_range(96, 9));
            else
                it.request_bytes = 16'($urandom_range(65535, 129));
        end
        else
        begin
            it.command = CMD_FREE;
            if ($urandom_range(99) < 88 && live_blocks.size() != 0)
            begin
                slot = $urandom_range(live_blocks.size() - 1);
                it.block_address = live_blocks[slot];
                live_blocks.delete(slot);
            end
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int gap_pct, input int stall_pct);
        req_item_t item;
        req_gap_pct = gap_pct;
        rsp_stall_pct = stall_pct;
        repeat (count)
        begin
            item = make_random_item();
            send_item(item, 1'b0, '0);
        end
    endtask

    // response side: ready pattern and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_outcomes.size() == 0)
                    report_mismatch("unexpected item, status", 32'(rsp.status), '0);
                else
                begin
                    oldest_outcome = predicted_outcomes.pop_front();
                    if (rsp.status !== oldest_outcome.status)
                        report_mismatch("status", 32'(rsp.status),
                                        32'(oldest_outcome.status));
                    if (rsp.granted_address !== oldest_outcome.granted_address)
                        report_mismatch("granted_address", 32'(rsp.granted_address),
                                        32'(oldest_outcome.granted_address));
                    if (rsp.class_bytes !== oldest_outcome.class_bytes)
                        report_mismatch("class_bytes", 32'(rsp.class_bytes),
                                        32'(oldest_outcome.class_bytes));
                    outcome_count[oldest_outcome.status]++;
                    items_checked++;
                end
            end
            if (hold_asks != hold_taken)
            begin
                hold_taken <= hold_asks;
                hold_left <= HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin
        script_row_t row;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_ready <= 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            class_head[c] = '0;
            class_has_free[c] = 1'b0;
            class_bumped[c] = 0;
        end
        for (int i = 0; i < LINK_DEPTH; i++)
            link_words[i] = '0;
        for (int s = 0; s < 4; s++)
            outcome_count[s] = 0;

        // directed script: size rounding, class ends, too large, lifo reuse,
        // unchecked frees (misaligned, never handed out, double)
        add_row(CMD_ALLOC, 16'd0,     16'hFFFF, 1'b1, ST_ALLOCATED, 16'h0000, 8'd8);
        add_row(CMD_ALLOC, 16'd1,     16'h0000, 1'b1, ST_ALLOCATED, 16'h0008, 8'd8);
        add_row(CMD_ALLOC, 16'd8,     16'h0000, 1'b1, ST_ALLOCATED, 16'h0010, 8'd8);
        add_row(CMD_ALLOC, 16'd9,     16'h0000, 1'b1, ST_ALLOCATED, 16'h1000, 8'd16);
        add_row(CMD_ALLOC, 16'd128,   16'h0000, 1'b1, ST_ALLOCATED, 16'hF000, 8'd128);
        add_row(CMD_ALLOC, 16'd121,   16'h0000, 1'b1, ST_ALLOCATED, 16'hF080, 8'd128);
        add_row(CMD_ALLOC, 16'd129,   16'h0000, 1'b1, ST_TOO_LARGE, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'hFFFF,  16'hFFFF, 1'b1, ST_TOO_LARGE, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd120,   16'h0000, 1'b1, ST_ALLOCATED, 16'hE000, 8'd120);
        add_row(CMD_FREE,  16'hFFFF,  16'hF000, 1'b1, ST_FREED,     16'h0000, 8'd128);
        add_row(CMD_FREE,  16'h0000,  16'hF080, 1'b1, ST_FREED,     16'h0000, 8'd128);
        add_row(CMD_ALLOC, 16'd128,   16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd128,   16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd128,   16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_FREE,  16'h0000,  16'hFFFF, 1'b1, ST_FREED,     16'h0000, 8'd128);
        add_row(CMD_ALLOC, 16'd113,   16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_FREE,  16'h0000,  16'h1001, 1'b1, ST_FREED,     16'h0000, 8'd16);
        add_row(CMD_FREE,  16'h0000,  16'h7ABC, 1'b1, ST_FREED,     16'h0000, 8'd64);
        add_row(CMD_ALLOC, 16'd64,    16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd57,    16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_FREE,  16'h0000,  16'h0013, 1'b1, ST_FREED,     16'h0000, 8'd8);
        add_row(CMD_FREE,  16'h0000,  16'h0013, 1'b1, ST_FREED,     16'h0000, 8'd8);
        add_row(CMD_ALLOC, 16'd7,     16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd7,     16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);
        add_row(CMD_ALLOC, 16'd16,    16'h0000, 1'b0, ST_ALLOCATED, 16'h0000, 8'd0);

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        foreach (script_rows[r])
        begin
            row = script_rows[r];
            send_item(row.item, row.typed, row.want);
        end

        // random part in four phases: no idling, request gaps, receiver stalls, both
        run_random(400, 0, 0);
        run_random(400, 71, 0);
        run_random(400, 0, 71);
        run_random(400, 7, 7);

        // long receiver hold-off while items keep coming
        hold_asks <= hold_asks + 1;
        run_random(50, 0, 0);

        // drain
        req_valid <= 1'b0;
        rsp_stall_pct = 0;
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
                 items_checked, mismatches);
        $display("outcomes: %0d allocated, %0d exhausted, %0d too large, %0d freed",
                 outcome_count[ST_ALLOCATED], outcome_count[ST_EXHAUSTED],
                 outcome_count[ST_TOO_LARGE], outcome_count[ST_FREED]);
        if (mismatches == 0)
            $display("tb_size_class_free_list_allocator_unit OK");
        else
            $display("tb_size_class_free_list_allocator_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/scfl_pkg.sv
src/scfl_decode.sv
src/scfl_class_store.sv
src/scfl_link_store.sv
src/size_class_free_list_allocator_unit.sv
bench/tb_size_class_free_list_allocator_unit.sv
